@@ sv/rms_normalize_vector_macros.svh @@
// assertion macros for the rms normalize block
`ifndef RMS_NORMALIZE_VECTOR_MACROS_SVH
`define RMS_NORMALIZE_VECTOR_MACROS_SVH

// implication checked every cycle outside reset
`define RNV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rnv check failed");

// next-cycle implication checked outside reset
`define RNV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rnv check failed");

`endif

@@ sv/rnv_pkg.sv @@
`default_nettype none
package rnv_pkg;

  localparam int MaxDimDefault = 64;
  localparam int EpsReset = 17;

  typedef struct packed {
    logic signed [15:0] element_value;
    logic signed [15:0] gain_weight;
    logic               row_end;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normalized_value;
    logic               last_of_row;
    logic               row_overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DIV,
    ST_SQRT,
    ST_EMIT_RD,
    ST_EMIT_MUL,
    ST_EMIT_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // store element and accumulate
    logic div_init;  // set up mean and reciprocal division
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic emit_rd;   // read stored element
    logic emit_mul1; // first product
    logic emit_mul2; // second product and rounding
    logic emit_next; // advance index / clear row on last
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic emit_last;
    logic row_empty;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ sv/rnv_ram.sv @@
`default_nettype none
module rnv_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
  input  wire logic [Width-1:0]                              wr_data,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
  output logic      [Width-1:0]                              rd_data
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ sv/rnv_ctrl.sv @@
`default_nettype none
module rnv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             row_end,
  input  wire rnv_pkg::dp_stat_t stat,
  output logic                  busy,
  output logic                  strobe,
  output rnv_pkg::dp_cmd_t      cmd
);
  rnv_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnv_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    strobe = 1'b0;
    unique case (state)
      rnv_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          if (row_end) begin
            cmd.div_init = 1'b1;
            state_next = rnv_pkg::ST_DIV;
          end
        end
      end
      rnv_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.sqrt_init = 1'b1;
          state_next = rnv_pkg::ST_SQRT;
        end
      end
      rnv_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_done) begin
          if (stat.row_empty) begin
            cmd.emit_next = 1'b1;
            state_next = rnv_pkg::ST_LOAD;
          end else begin
            state_next = rnv_pkg::ST_EMIT_RD;
          end
        end
      end
      rnv_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = rnv_pkg::ST_EMIT_MUL;
      end
      rnv_pkg::ST_EMIT_MUL: begin
        cmd.emit_mul1 = 1'b1;
        state_next = rnv_pkg::ST_EMIT_OUT;
      end
      rnv_pkg::ST_EMIT_OUT: begin
        cmd.emit_mul2 = 1'b1;
        state_next = rnv_pkg::ST_EMIT_RD;
        if (stat.emit_last) begin
          state_next = rnv_pkg::ST_LOAD;
        end
      end
      default: state_next = rnv_pkg::ST_LOAD;
    endcase
    // the result register is loaded in emit_out and shown in the cycle after
    cmd.emit_next = cmd.emit_next | cmd.emit_mul2;
    strobe = 1'b0;
  end
endmodule
`default_nettype wire

@@ sv/rnv_datapath.sv @@
`default_nettype none
module rnv_datapath #(
  parameter int MaxDim = rnv_pkg::MaxDimDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rnv_pkg::in_word_t in_word,
  input  wire logic [23:0]       epsilon,
  input  wire rnv_pkg::dp_cmd_t  cmd,
  output rnv_pkg::dp_stat_t      stat,
  output logic                   result_valid,
  output rnv_pkg::out_word_t     result
);
  localparam int AW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int CW = $clog2(MaxDim + 1);

  // row accumulation
  logic [37:0]   square_sum;
  logic [CW-1:0] element_count;
  logic          overflow_seen;
  logic [15:0]   ax_in;
  logic [31:0]   sq_in;
  logic          room;

  assign room  = element_count < CW'(MaxDim);
  assign ax_in = in_word.element_value[15] ? 16'(-in_word.element_value)
                                           : in_word.element_value;
  assign sq_in = ax_in * ax_in;

  // memories for the stored row
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   x_rd, w_rd;
  logic [CW-1:0] emit_idx;

  // read one word ahead while the index advances, the read is registered
  assign wr_addr = element_count[AW-1:0];
  assign rd_addr = cmd.emit_next ? AW'(emit_idx + CW'(1)) : emit_idx[AW-1:0];

  rnv_ram #(.Width(16), .Depth(MaxDim)) u_xram (
    .clk(clk), .wr_en(cmd.load && room), .wr_addr(wr_addr),
    .wr_data(in_word.element_value), .rd_addr(rd_addr), .rd_data(x_rd)
  );
  rnv_ram #(.Width(16), .Depth(MaxDim)) u_wram (
    .clk(clk), .wr_en(cmd.load && room), .wr_addr(wr_addr),
    .wr_data(in_word.gain_weight), .rd_addr(rd_addr), .rd_data(w_rd)
  );

  // shared restoring divider: first sum/n, then 2^56/ms
  // phase 0 divides square_sum (38 bits) by count, phase 1 divides 2^56 by ms
  logic        div_phase;
  logic [56:0] dividend;
  logic [38:0] divisor;
  logic [39:0] rem;
  logic [5:0]  div_cnt;
  logic [39:0] rem_sh;
  logic        ge;
  logic [38:0] mean_ms;

  assign rem_sh = {rem[38:0], dividend[56]};
  assign ge     = rem_sh >= {1'b0, divisor};

  // mean square plus epsilon, never zero
  always_comb begin
    if (divisor == '0) begin
      mean_ms = 39'(epsilon);
    end else begin
      mean_ms = {1'b0, dividend[37:0]} + 39'(epsilon);
    end
    if (mean_ms == '0) begin
      mean_ms = 39'd1;
    end
  end

  // integer square root unit, one root bit per cycle
  logic [57:0] sq_q;
  logic [57:0] sq_rem;
  logic [28:0] sq_root;
  logic [4:0]  sq_cnt;
  logic [58:0] sq_trial;
  logic [58:0] sq_rem_sh;

  assign sq_rem_sh = {sq_rem[56:0], sq_q[57:56]};
  assign sq_trial  = {28'd0, sq_root, 2'b01};

  assign stat.div_done  = div_phase && (div_cnt == 6'd0);
  assign stat.sqrt_done = (sq_cnt == 5'd0);
  assign stat.row_empty = (element_count == '0);
  assign stat.emit_last = (emit_idx + CW'(1)) == element_count;

  // emit pipeline
  logic [15:0] ax_e, aw_e;
  logic        neg_e;
  logic [44:0] xs;
  logic        neg_m;
  logic [60:0] prod;
  logic [31:0] mag;
  logic signed [15:0] sat;

  assign prod = xs * aw_e;
  assign mag  = 32'((prod + 61'(1 << 29)) >> 30);
  always_comb begin
    if (neg_m) begin
      sat = (mag > 32'd32768) ? -16'sd32768 : 16'(-mag);
    end else begin
      sat = (mag > 32'd32767) ? 16'sd32767 : 16'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      element_count <= '0;
      overflow_seen <= 1'b0;
      emit_idx      <= '0;
      div_phase     <= 1'b0;
      div_cnt       <= '0;
      sq_cnt        <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= cmd.emit_mul2;
      // load and accumulate
      if (cmd.load) begin
        if (room) begin
          square_sum    <= square_sum + 38'(sq_in);
          element_count <= element_count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      // divider control
      if (cmd.div_init) begin
        div_phase <= 1'b0;
        div_cnt   <= 6'd38;
      end else if (cmd.div_step) begin
        if (div_cnt != 6'd0) begin
          div_cnt <= div_cnt - 6'd1;
        end else if (!div_phase) begin
          div_phase <= 1'b1;
          div_cnt   <= 6'd57;
        end
      end
      if (cmd.sqrt_init) begin
        sq_cnt <= 5'd29;
      end else if (cmd.sqrt_step && sq_cnt != 5'd0) begin
        sq_cnt <= sq_cnt - 5'd1;
      end
      // index advance and end of row
      if (cmd.emit_next) begin
        if (stat.emit_last || stat.row_empty) begin
          emit_idx      <= '0;
          square_sum    <= '0;
          element_count <= '0;
          overflow_seen <= 1'b0;
        end else begin
          emit_idx <= emit_idx + CW'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dividend <= {square_sum + 38'(sq_in & {32{cmd.load && room}}), 19'd0};
      divisor  <= 39'(element_count + CW'(cmd.load && room));
      rem      <= '0;
    end else if (cmd.div_step) begin
      if (div_cnt != 6'd0) begin
        rem      <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
        dividend <= {dividend[55:0], ge};
      end else if (!div_phase) begin
        // quotient bits sit in the low 38 bits of dividend
        divisor  <= mean_ms;
        dividend <= {1'b1, 56'd0};
        rem      <= '0;
      end
    end
    if (cmd.sqrt_init) begin
      sq_q    <= {1'b0, dividend};
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step && sq_cnt != 5'd0) begin
      sq_q <= {sq_q[55:0], 2'b00};
      if (sq_rem_sh >= sq_trial) begin
        sq_rem  <= 58'(sq_rem_sh - sq_trial);
        sq_root <= {sq_root[27:0], 1'b1};
      end else begin
        sq_rem  <= 58'(sq_rem_sh);
        sq_root <= {sq_root[27:0], 1'b0};
      end
    end
    if (cmd.emit_rd) begin
      ax_e  <= x_rd[15] ? 16'(-x_rd) : x_rd;
      aw_e  <= w_rd[15] ? 16'(-w_rd) : w_rd;
      neg_e <= x_rd[15] ^ w_rd[15];
    end
    if (cmd.emit_mul1) begin
      xs    <= 45'(ax_e) * 45'(sq_root);
      neg_m <= neg_e;
    end
    if (cmd.emit_mul2) begin
      result.normalized_value <= sat;
      result.last_of_row      <= stat.emit_last;
      result.row_overflow     <= overflow_seen;
    end
  end
endmodule
`default_nettype wire

@@ sv/rms_normalize_vector.sv @@
// channel | direction | handshake              | payload
// command | in        | start high, busy low   | in_word (element, weight, row end)
// result  | out       | one-cycle done strobe  | out_word (value, last, overflow)
// config  | in        | cfg_valid and cfg_ready| cfg_data (epsilon, 24 bits)
// an element that does not close its row is stored while busy stays low
// a closing element runs the divider (38 + 57 steps) and then the root (29 steps);
// then each word passes through the emit_rd, emit_mul and emit_out states
// busy stays high after a closing word until the last word of its row is emitted
// rst is synchronous; epsilon returns to 17, the row is cleared
// the receiver cannot stall; busy holds off the sender during a row's output
`default_nettype none
`include "rms_normalize_vector_macros.svh"
module rms_normalize_vector #(
  parameter int MaxDim = rnv_pkg::MaxDimDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire rnv_pkg::in_word_t in_word,
  output logic                   done,
  output rnv_pkg::out_word_t     out_word,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [23:0]       cfg_data
);
  logic [23:0]       epsilon;
  rnv_pkg::dp_cmd_t  cmd;
  rnv_pkg::dp_stat_t stat;
  logic              strobe_unused;

  assign cfg_ready = 1'b1;

  // epsilon register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 24'(rnv_pkg::EpsReset);
    end else if (cfg_valid && cfg_ready) begin
      epsilon <= cfg_data;
    end
  end

  rnv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .row_end(in_word.row_end),
    .stat(stat), .busy(busy), .strobe(strobe_unused), .cmd(cmd)
  );

  rnv_datapath #(.MaxDim(MaxDim)) u_dp (
    .clk(clk), .rst(rst), .in_word(in_word), .epsilon(epsilon), .cmd(cmd),
    .stat(stat), .result_valid(done), .result(out_word)
  );

  `RNV_ASSERT_IMP(a_no_done_idle, clk, rst, !busy, !done || $past(busy))
  `RNV_ASSERT_NEXT(a_close_busy, clk, rst, start && !busy && in_word.row_end, busy)
  `RNV_ASSERT_IMP(a_strobe_quiet, clk, rst, 1'b1, !strobe_unused)
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDim = rnv_pkg::MaxDimDefault;
  localparam int SettleCycles = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rnv_pkg::in_word_t in_word = '0;
  logic done;
  rnv_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;

  rms_normalize_vector #(.MaxDim(MaxDim)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .done(done), .out_word(out_word), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // normalizer shadow state
  logic [15:0] row_x [MaxDim];
  logic [15:0] row_g [MaxDim];
  logic [37:0] sq_sum = '0;
  int unsigned row_len = 0;
  bit row_trunc = 1'b0;
  logic [23:0] eps_reg = 24'(rnv_pkg::EpsReset);
  rnv_pkg::out_word_t norm_words_q[$];

  int mismatches = 0;
  bit fixed_valid = 1'b0;
  logic signed [15:0] fixed_value = '0;

  // bitwise integer square root, result fits in 29 bits
  function automatic longint unsigned int_sqrt(longint unsigned q);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r;
  endfunction

  // store one element; on the row mark, queue the normalized row
  task automatic normalize_word(rnv_pkg::in_word_t w);
    int xi, gi;
    longint unsigned ax, ag, ms, scale, mag;
    bit neg;
    rnv_pkg::out_word_t o;
    xi = w.element_value;
    if (row_len < MaxDim) begin
      ax = (xi < 0) ? -xi : xi;
      row_x[row_len] = w.element_value;
      row_g[row_len] = w.gain_weight;
      sq_sum = 38'(sq_sum + ax * ax);
      row_len++;
    end else begin
      row_trunc = 1'b1;
    end
    if (!w.row_end) return;
    ms = (row_len != 0) ? (longint'(sq_sum) / row_len) : 0;
    ms = ms + eps_reg;
    if (ms == 0) ms = 1;
    scale = int_sqrt((64'd1 << 56) / ms);
    for (int k = 0; k < row_len; k++) begin
      xi = $signed(row_x[k]);
      gi = $signed(row_g[k]);
      neg = (xi < 0) != (gi < 0);
      ax = (xi < 0) ? -xi : xi;
      ag = (gi < 0) ? -gi : gi;
      mag = (ax * scale * ag + (64'd1 << 29)) >> 30;
      if (neg) o.normalized_value = (mag > 32768) ? -16'sd32768 : 16'(-longint'(mag));
      else o.normalized_value = (mag > 32767) ? 16'sd32767 : 16'(mag);
      o.last_of_row = (k + 1 == row_len);
      o.row_overflow = row_trunc;
      norm_words_q = {norm_words_q, o};
    end
    sq_sum = '0;
    row_len = 0;
    row_trunc = 1'b0;
  endtask

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    rnv_pkg::out_word_t e;
    if (!rst) begin
      if (cfg_valid && cfg_ready) eps_reg = cfg_data;
      if (start && !busy) begin
        normalize_word(in_word);
        if (fixed_valid && in_word.row_end)
          norm_words_q[norm_words_q.size() - 1].normalized_value = fixed_value;
      end
      if (done) begin
        if (norm_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_word);
        end else begin
          e = norm_words_q.pop_front();
          if (out_word.normalized_value !== e.normalized_value ||
              out_word.last_of_row !== e.last_of_row ||
              out_word.row_overflow !== e.row_overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                       e.normalized_value, e.last_of_row, e.row_overflow,
                       out_word.normalized_value, out_word.last_of_row,
                       out_word.row_overflow);
          end
        end
      end
    end
  end

  bit no_gaps = 1'b0;

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one word at the falling edge, hold until taken
  task automatic send_word(logic signed [15:0] x, logic signed [15:0] g, bit last,
                           bit has_fixed = 0, logic signed [15:0] fixed = 0);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_word <= '{element_value: x, gain_weight: g, row_end: last};
    fixed_valid <= has_fixed;
    fixed_value <= fixed;
    do @(posedge clk); while (busy);
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
    fixed_valid <= 1'b0;
  endtask

  // write epsilon once the block has drained
  task automatic write_eps(logic [23:0] v);
    release_start();
    wait (norm_words_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return -16'sd32768;
      2: return 16'($urandom_range(0, 8191)) - 16'sd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_row(int len, bit zeros);
    for (int i = 0; i < len; i++)
      send_word(zeros ? 16'sd0 : rand_field(), rand_field(), i == len - 1);
  endtask

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] g;
    bit last;
    bit has_fixed;
    logic signed [15:0] fixed;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{16'sd0, 16'sd32767, 1, 1, 16'sd0},
    '{16'sd4096, 16'sd16384, 1, 1, 16'sd4096},
    '{-16'sd4096, 16'sd16384, 1, 1, -16'sd4096},
    '{16'sd4096, -16'sd16384, 1, 1, -16'sd4096},
    '{16'sd32767, 16'sd32767, 1, 0, 16'sd0},
    '{-16'sd32768, -16'sd32768, 1, 0, 16'sd0},
    '{-16'sd32768, 16'sd32767, 1, 0, 16'sd0},
    '{16'sd1, 16'sd1, 0, 0, 16'sd0},
    '{16'sd32767, -16'sd32768, 0, 0, 16'sd0},
    '{-16'sd1, 16'sd16384, 1, 0, 16'sd0},
    '{16'sd0, 16'sd0, 0, 0, 16'sd0},
    '{16'sd0, -16'sd1, 0, 0, 16'sd0},
    '{16'sd1, 16'sd32767, 1, 0, 16'sd0},
    '{16'sh5555, 16'shAAAA, 0, 0, 16'sd0},
    '{16'shAAAA, 16'sh5555, 1, 0, 16'sd0}
  };

  logic [23:0] eps_list[] = '{24'd0, 24'hFFFFFF, 24'd1, 24'd17, 24'd0};

  initial begin
    int len, r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset epsilon
    foreach (directed_rows[i])
      send_word(directed_rows[i].x, directed_rows[i].g, directed_rows[i].last,
                directed_rows[i].has_fixed, directed_rows[i].fixed);

    // random rows under each epsilon setting
    foreach (eps_list[p]) begin
      write_eps((p == 3) ? 24'($urandom) : eps_list[p]);
      if (p == 0) send_row(3, 1);
      for (int n = 0; n < 80; ) begin
        no_gaps = ($urandom_range(0, 5) == 0);
        r = $urandom_range(0, 19);
        if (r < 14) len = $urandom_range(1, 8);
        else if (r < 18) len = $urandom_range(9, MaxDim);
        else len = $urandom_range(MaxDim + 1, MaxDim + 4);
        send_row(len, $urandom_range(0, 9) == 0);
        n += len;
      end
    end
    no_gaps = 1'b0;
    release_start();

    wait (norm_words_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0 && norm_words_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
